[hw/rtl/acc_enc_pkg.sv]
`timescale 1ns / 1ps

package acc_enc_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_PRESET_ENABLE  = 3'd0,
        REG_MAX_TARGET     = 3'd1,
        REG_MIN_TARGET     = 3'd2,
        REG_WINDOW_MS      = 3'd3,
        REG_RESET_GAP_MS   = 3'd4,
        REG_FAST_THRESHOLD = 3'd5
    } cfg_reg_t;

    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [9:0]  MAX_TARGET_RST     = 10'd450;
    localparam logic [9:0]  MIN_TARGET_RST     = 10'd200;
    localparam logic [15:0] WINDOW_MS_RST      = 16'd1000;
    localparam logic [15:0] RESET_GAP_MS_RST   = 16'd800;
    localparam logic [7:0]  FAST_THRESHOLD_RST = 8'd3;

    // Target and step constants
    localparam logic [9:0]  TARGET_RST   = 10'd300;
    localparam logic [9:0]  PRESET_BASE  = 10'd300;
    localparam logic [9:0]  PRESET_PITCH = 10'd50;
    localparam logic [1:0]  SLOT_MIN     = 2'd1;
    localparam logic [1:0]  SLOT_MAX     = 2'd3;
    localparam logic [5:0]  STEP_BASE    = 6'd5;
    localparam logic [7:0]  MAX_LEVEL    = 8'd4;
    localparam logic [7:0]  FAST_SAT     = 8'd255;
    localparam logic [15:0] HITS_SAT     = 16'd65535;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        increase;
    } in_item_t;

    typedef struct packed {
        logic [9:0] target_temp;
        logic [5:0] applied_step;
        logic [1:0] preset_index;
    } out_item_t;

endpackage

[hw/rtl/accelerated_encoder_setpoint.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// -------   ---------  ---------------------  --------------------------------------
// in        input      in_valid / in_ready    in_item  (now_ms, increase)
// out       output     out_valid / out_ready  out_item (target_temp, applied_step,
//                                                       preset_index)
// cfg       input      cfg_we (no wait)       cfg_index, cfg_data
//
// One item per cycle while in_ready is high. An accepted item is fully processed in
// the cycle it is accepted: the tracker and target state update at that edge and
// the result lands in the output register, visible in the following cycle.
// in_ready is high while the output register is empty or being drained, so a
// stalled consumer holds at most one finished item and back-pressures input.
// Reset (rst_n, async, active low) restores the configuration defaults, an
// uninitialized rate tracker, target 300 and preset slot 1.

module accelerated_encoder_setpoint
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  acc_enc_pkg::in_item_t               in_item,

    output logic                                out_valid,
    input  logic                                out_ready,
    output acc_enc_pkg::out_item_t              out_item,

    input  logic                                cfg_we,
    input  logic [2:0]                          cfg_index,
    input  logic [acc_enc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers
    logic        preset_enable_reg;
    logic [9:0]  max_target_reg;
    logic [9:0]  min_target_reg;
    logic [15:0] window_ms_reg;
    logic [15:0] reset_gap_ms_reg;
    logic [7:0]  fast_threshold_reg;

    // Tracker and target state
    logic [31:0] last_time_reg,    last_time_next;
    logic [31:0] window_start_reg, window_start_next;
    logic [15:0] window_hits_reg,  window_hits_next;
    logic [7:0]  fast_seconds_reg, fast_seconds_next;
    logic [9:0]  target_reg,       target_next;
    logic [1:0]  slot_reg,         slot_next;

    // Output register
    logic                   out_valid_reg;
    acc_enc_pkg::out_item_t out_item_reg, out_item_next;

    logic in_fire;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // ------------------------------------------------------------------
    // Rate tracker. The uninitialized and long-gap cases both restart the
    // window at now_ms, so the window test then reduces to window_ms == 0.
    // Both subtractions run in parallel.
    // ------------------------------------------------------------------
    logic        uninit;
    logic [31:0] gap_diff;
    logic [31:0] win_diff;
    logic        restart;
    logic        expired;
    logic [15:0] hits_eff;
    logic [7:0]  fast_eff;
    logic [15:0] hits_trk;
    logic [7:0]  fast_trk;
    logic [31:0] ws_trk;
    logic [5:0]  trk_step;

    always_comb
    begin
        uninit   = (last_time_reg == 32'd0);
        gap_diff = in_item.now_ms - last_time_reg;
        win_diff = in_item.now_ms - window_start_reg;
        restart  = uninit || (gap_diff > {16'd0, reset_gap_ms_reg});
        if (restart)
        begin
            expired  = (window_ms_reg == 16'd0);
            hits_eff = 16'd0;
            fast_eff = 8'd0;
            ws_trk   = in_item.now_ms;
        end
        else
        begin
            expired  = (win_diff >= {16'd0, window_ms_reg});
            hits_eff = window_hits_reg;
            fast_eff = fast_seconds_reg;
            ws_trk   = window_start_reg;
        end

        hits_trk = hits_eff;
        fast_trk = fast_eff;
        if (expired)
        begin
            // settle the finished window
            if (hits_eff > {8'd0, fast_threshold_reg})
            begin
                if (fast_eff < acc_enc_pkg::FAST_SAT)
                begin
                    fast_trk = fast_eff + 8'd1;
                end
            end
            else
            begin
                fast_trk = 8'd0;
            end
            hits_trk = 16'd0;
            ws_trk   = in_item.now_ms;
        end
        if (hits_trk < acc_enc_pkg::HITS_SAT)
        begin
            hits_trk = hits_trk + 16'd1;
        end

        // step: 5 when slow, else 10 per fast-second level up to level 4
        if (fast_trk == 8'd0)
        begin
            trk_step = acc_enc_pkg::STEP_BASE;
        end
        else if (fast_trk >= acc_enc_pkg::MAX_LEVEL)
        begin
            trk_step = 6'd40;
        end
        else
        begin
            trk_step = {1'b0, fast_trk[1:0], 3'b000} + {2'b00, fast_trk[1:0], 1'b0};
        end
    end

    // ------------------------------------------------------------------
    // Target update and preset stepping
    // ------------------------------------------------------------------
    logic        attempt;
    logic [9:0]  floor_v;
    logic [10:0] up_sum;
    logic [10:0] dn_diff;
    logic [1:0]  slot_base;
    logic [1:0]  slot_new;
    logic [5:0]  step_used;
    logic [9:0]  preset_target;

    always_comb
    begin
        floor_v = (min_target_reg >= 10'd5) ? (min_target_reg - 10'd5) : 10'd0;
        attempt = in_item.increase ? (target_reg < max_target_reg)
                                   : (target_reg >= min_target_reg);
        step_used = attempt ? trk_step : 6'd0;
        up_sum  = {1'b0, target_reg} + {5'd0, step_used};
        dn_diff = {1'b0, target_reg} - {5'd0, step_used};

        // a zero slot is treated as the first preset
        slot_base = (slot_reg == 2'd0) ? acc_enc_pkg::SLOT_MIN : slot_reg;
        slot_new  = slot_base;
        if (in_item.increase)
        begin
            if (slot_base < acc_enc_pkg::SLOT_MAX)
            begin
                slot_new = slot_base + 2'd1;
            end
        end
        else if (slot_base > acc_enc_pkg::SLOT_MIN)
        begin
            slot_new = slot_base - 2'd1;
        end

        unique case (slot_new)
            2'd2:    preset_target = acc_enc_pkg::PRESET_BASE + acc_enc_pkg::PRESET_PITCH;
            2'd3:    preset_target = acc_enc_pkg::PRESET_BASE
                                     + {acc_enc_pkg::PRESET_PITCH[8:0], 1'b0};
            default: preset_target = acc_enc_pkg::PRESET_BASE;
        endcase

        last_time_next    = last_time_reg;
        window_start_next = window_start_reg;
        window_hits_next  = window_hits_reg;
        fast_seconds_next = fast_seconds_reg;
        target_next       = target_reg;
        slot_next         = slot_reg;

        if (preset_enable_reg)
        begin
            slot_next   = slot_new;
            target_next = preset_target;
        end
        else
        begin
            if (attempt)
            begin
                last_time_next    = in_item.now_ms;
                window_start_next = ws_trk;
                window_hits_next  = hits_trk;
                fast_seconds_next = fast_trk;
            end
            if (in_item.increase)
            begin
                // clamp applies even when no step was taken
                target_next = (up_sum > {1'b0, max_target_reg}) ? max_target_reg
                                                                 : up_sum[9:0];
            end
            else
            begin
                // dn_diff wraps negative into bit 10
                target_next = (dn_diff[10] || (dn_diff[9:0] < floor_v)) ? floor_v
                                                                        : dn_diff[9:0];
            end
        end

        out_item_next.target_temp  = target_next;
        out_item_next.applied_step = preset_enable_reg ? 6'd0 : step_used;
        out_item_next.preset_index = slot_next;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preset_enable_reg  <= 1'b0;
            max_target_reg     <= acc_enc_pkg::MAX_TARGET_RST;
            min_target_reg     <= acc_enc_pkg::MIN_TARGET_RST;
            window_ms_reg      <= acc_enc_pkg::WINDOW_MS_RST;
            reset_gap_ms_reg   <= acc_enc_pkg::RESET_GAP_MS_RST;
            fast_threshold_reg <= acc_enc_pkg::FAST_THRESHOLD_RST;
            last_time_reg      <= 32'd0;
            window_start_reg   <= 32'd0;
            window_hits_reg    <= 16'd0;
            fast_seconds_reg   <= 8'd0;
            target_reg         <= acc_enc_pkg::TARGET_RST;
            slot_reg           <= acc_enc_pkg::SLOT_MIN;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (acc_enc_pkg::cfg_reg_t'(cfg_index))
                    acc_enc_pkg::REG_PRESET_ENABLE:  preset_enable_reg  <= cfg_data[0];
                    acc_enc_pkg::REG_MAX_TARGET:     max_target_reg     <= cfg_data[9:0];
                    acc_enc_pkg::REG_MIN_TARGET:     min_target_reg     <= cfg_data[9:0];
                    acc_enc_pkg::REG_WINDOW_MS:      window_ms_reg      <= cfg_data[15:0];
                    acc_enc_pkg::REG_RESET_GAP_MS:   reset_gap_ms_reg   <= cfg_data[15:0];
                    acc_enc_pkg::REG_FAST_THRESHOLD: fast_threshold_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end

            if (in_fire)
            begin
                last_time_reg    <= last_time_next;
                window_start_reg <= window_start_next;
                window_hits_reg  <= window_hits_next;
                fast_seconds_reg <= fast_seconds_next;
                target_reg       <= target_next;
                slot_reg         <= slot_next;
                out_valid_reg    <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

[tb/accelerated_encoder_setpoint_tb.sv]
`timescale 1ns / 1ps

module accelerated_encoder_setpoint_tb;

    // Watchdog: cycles with no handshake on either channel before giving up.
    // Longest legal quiet stretch is the long output hold (HOLD_CYCLES).
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int TEMP_CEIL   = 1023;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    acc_enc_pkg::in_item_t  in_item;
    logic                   out_valid;
    logic                   out_ready;
    acc_enc_pkg::out_item_t out_item;
    logic                   cfg_we;
    logic [2:0]             cfg_index;
    logic [acc_enc_pkg::CFG_DATA_W-1:0] cfg_data;

    accelerated_encoder_setpoint dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Setpoint predictor: shadow copy of the config and tracker state
    // ------------------------------------------------------------------
    logic        cfg_preset;
    logic [9:0]  cfg_max;
    logic [9:0]  cfg_min;
    logic [15:0] cfg_window;
    logic [15:0] cfg_gap;
    logic [7:0]  cfg_thr;

    logic [31:0] last_time;     // 0 = tracker not yet started
    logic [31:0] win_origin;
    logic [15:0] win_hits;
    logic [7:0]  fast_secs;
    logic [9:0]  target;
    logic [1:0]  slot;

    acc_enc_pkg::out_item_t setpoint_q[$]; // expected results, oldest first
    int          error_cnt = 0;
    int          idle_cycles = 0;

    // Stimulus bookkeeping
    logic [31:0] clock_ms = 32'd0;  // running detent timestamp
    bit          pace_gaps = 1'b1;  // sender inserts random gaps between bursts
    int          burst_left = 0;
    bit          hold_req = 1'b0;   // ask the receiver for one long hold-off
    bit          holding = 1'b0;

    task automatic reset_model();
        cfg_preset = 1'b0;
        cfg_max    = acc_enc_pkg::MAX_TARGET_RST;
        cfg_min    = acc_enc_pkg::MIN_TARGET_RST;
        cfg_window = acc_enc_pkg::WINDOW_MS_RST;
        cfg_gap    = acc_enc_pkg::RESET_GAP_MS_RST;
        cfg_thr    = acc_enc_pkg::FAST_THRESHOLD_RST;
        last_time  = '0;
        win_origin = '0;
        win_hits   = '0;
        fast_secs  = '0;
        target     = acc_enc_pkg::TARGET_RST;
        slot       = acc_enc_pkg::SLOT_MIN;
    endtask

    // Rate tracker: advances only when an adjustment is attempted and
    // returns the step size for this detent.
    function automatic logic [5:0] tracker_step_size(input logic [31:0] now);
        logic [31:0] since_last;
        logic [31:0] since_window;
        logic [7:0]  level;
        if (last_time == 32'd0)
        begin
            last_time  = now;
            win_origin = now;
            win_hits   = '0;
            fast_secs  = '0;
        end
        // both distances are modulo 2^32
        since_last = now - last_time;
        if (since_last > {16'd0, cfg_gap})
        begin
            win_origin = now;
            win_hits   = '0;
            fast_secs  = '0;
        end
        since_window = now - win_origin;
        if (since_window >= {16'd0, cfg_window})
        begin
            if (win_hits > {8'd0, cfg_thr})
            begin
                if (fast_secs < acc_enc_pkg::FAST_SAT)
                    fast_secs++;
            end
            else
                fast_secs = '0;
            win_hits   = '0;
            win_origin = now;
        end
        if (win_hits < acc_enc_pkg::HITS_SAT)
            win_hits++;
        last_time = now;
        if (fast_secs == 8'd0)
            return acc_enc_pkg::STEP_BASE;
        level = (fast_secs > acc_enc_pkg::MAX_LEVEL) ? acc_enc_pkg::MAX_LEVEL : fast_secs;
        return 6'(int'(level) * int'(acc_enc_pkg::STEP_BASE) * 2);
    endfunction

    function automatic acc_enc_pkg::out_item_t next_setpoint(input acc_enc_pkg::in_item_t it);
        acc_enc_pkg::out_item_t res;
        logic [5:0] step;
        int         t;
        int         floor_t;
        step = '0;
        if (cfg_preset)
        begin
            if (slot < acc_enc_pkg::SLOT_MIN)
                slot = acc_enc_pkg::SLOT_MIN;
            if (it.increase)
            begin
                if (slot < acc_enc_pkg::SLOT_MAX)
                    slot++;
            end
            else if (slot > acc_enc_pkg::SLOT_MIN)
                slot--;
            target = acc_enc_pkg::PRESET_BASE
                     + {8'd0, slot - acc_enc_pkg::SLOT_MIN} * acc_enc_pkg::PRESET_PITCH;
        end
        else
        begin
            t = int'(target);
            if (it.increase)
            begin
                if (target < cfg_max)
                begin
                    step = tracker_step_size(it.now_ms);
                    t += int'(step);
                end
                // clamp applies even without a step
                if (t > int'(cfg_max))
                    t = int'(cfg_max);
            end
            else
            begin
                floor_t = int'(cfg_min) - 5;
                if (floor_t < 0)
                    floor_t = 0;
                if (target >= cfg_min)
                begin
                    step = tracker_step_size(it.now_ms);
                    t -= int'(step);
                end
                if (t < floor_t)
                    t = floor_t;
            end
            if (t < 0)
                t = 0;
            if (t > TEMP_CEIL)
                t = TEMP_CEIL;
            target = t[9:0];
        end
        res.target_temp  = target;
        res.applied_step = step;
        res.preset_index = slot;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Sender side. Every task that consumes time between items first drops
    // in_valid, so a stale item is never offered twice.
    // ------------------------------------------------------------------
    task automatic send_detent(input logic [31:0] now, input logic up);
        acc_enc_pkg::in_item_t it;
        it.now_ms   = now;
        it.increase = up;
        if (pace_gaps)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                          : $urandom_range(1, 30);
            end
            burst_left--;
        end
        in_valid <= 1'b1;
        in_item  <= it;
        // handshake is decided mid-cycle, where all inputs are stable
        do @(negedge clk); while (!in_ready);
        setpoint_q.push_back(next_setpoint(it));
        @(posedge clk);
    endtask

    // Stop offering items and wait for every expected result to drain.
    task automatic settle_outputs();
        in_valid <= 1'b0;
        while (setpoint_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Only called while the block is idle.
    task automatic write_reg(input acc_enc_pkg::cfg_reg_t idx,
                             input logic [acc_enc_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            acc_enc_pkg::REG_PRESET_ENABLE:  cfg_preset = val[0];
            acc_enc_pkg::REG_MAX_TARGET:     cfg_max    = val[9:0];
            acc_enc_pkg::REG_MIN_TARGET:     cfg_min    = val[9:0];
            acc_enc_pkg::REG_WINDOW_MS:      cfg_window = val;
            acc_enc_pkg::REG_RESET_GAP_MS:   cfg_gap    = val;
            acc_enc_pkg::REG_FAST_THRESHOLD: cfg_thr    = val[7:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_config(input logic pe, input logic [9:0] mx, input logic [9:0] mn,
                                input logic [15:0] win, input logic [15:0] gap,
                                input logic [7:0] thr);
        write_reg(acc_enc_pkg::REG_PRESET_ENABLE, {15'd0, pe});
        write_reg(acc_enc_pkg::REG_MAX_TARGET, {6'd0, mx});
        write_reg(acc_enc_pkg::REG_MIN_TARGET, {6'd0, mn});
        write_reg(acc_enc_pkg::REG_WINDOW_MS, win);
        write_reg(acc_enc_pkg::REG_RESET_GAP_MS, gap);
        write_reg(acc_enc_pkg::REG_FAST_THRESHOLD, {8'd0, thr});
    endtask

    // Either end of a range, or somewhere in between.
    function automatic int corner_pick(input int lo, input int hi);
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // Bursts of detents mostly in one direction at a pace tuned to the current
    // window and threshold so fast seconds build up; some slow windows and
    // long gaps break the streak, and noise_pct percent are fully random.
    task automatic spin_detents(input int count, input int noise_pct);
        int   run_left;
        logic dir;
        int   win;
        int   gp;
        int   fast_hi;
        int   roll;
        int   delta;
        run_left = 0;
        dir      = 1'b1;
        for (int i = 0; i < count; i++)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(4, 30);
                dir      = 1'($urandom_range(0, 1));
            end
            run_left--;
            if ($urandom_range(0, 99) < noise_pct)
            begin
                send_detent($urandom, 1'($urandom_range(0, 1)));
                continue;
            end
            win = int'(cfg_window);
            gp  = int'(cfg_gap);
            fast_hi = win / (int'(cfg_thr) + 2);
            if (fast_hi > gp)
                fast_hi = gp;
            roll = $urandom_range(0, 99);
            if (roll < 80)
                delta = $urandom_range(0, fast_hi);
            else if (roll < 92)
                delta = $urandom_range(win / 2, win + win / 2);
            else
                delta = gp + $urandom_range(1, 500);
            clock_ms = clock_ms + 32'(delta);
            send_detent(clock_ms, ($urandom_range(0, 9) == 0) ? !dir : dir);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Default config: start-up with timestamp 0, window settling, idle gap
    // clearing the tracker, and timestamp wrap.
    task automatic test_directed_tracker();
        send_detent(32'd0, 1'b1);       // tracker stays unstarted
        send_detent(32'd0, 1'b0);
        send_detent(32'd100, 1'b1);     // tracker starts here
        send_detent(32'd300, 1'b1);
        send_detent(32'd500, 1'b1);
        send_detent(32'd700, 1'b1);
        send_detent(32'd1100, 1'b1);    // busy window settles -> first fast second
        send_detent(32'd1950, 1'b0);    // gap over limit clears the tracker
        send_detent(32'hFFFF_FFFF, 1'b1);
        send_detent(32'h0000_0010, 1'b1); // short gap across the wrap
        clock_ms = 32'h0000_0010;
        settle_outputs();
    endtask

    // Clamping at both limits, with and without an attempted step.
    task automatic test_directed_limits();
        write_reg(acc_enc_pkg::REG_MAX_TARGET, 16'd310);
        write_reg(acc_enc_pkg::REG_MIN_TARGET, 16'd300);
        send_detent(clock_ms + 32'd1, 1'b1);  // above max: clamp down, no step
        send_detent(clock_ms + 32'd2, 1'b1);
        send_detent(clock_ms + 32'd3, 1'b0);
        send_detent(clock_ms + 32'd4, 1'b0);
        send_detent(clock_ms + 32'd5, 1'b0);  // reaches min - 5
        send_detent(clock_ms + 32'd6, 1'b0);  // below min: held at floor
        settle_outputs();
        write_reg(acc_enc_pkg::REG_MAX_TARGET, 16'd1023);
        write_reg(acc_enc_pkg::REG_MIN_TARGET, 16'd1023);
        send_detent(clock_ms + 32'd7, 1'b0);  // below floor: clamp up
        send_detent(clock_ms + 32'd8, 1'b1);
        send_detent(clock_ms + 32'd9, 1'b1);
        settle_outputs();
        write_reg(acc_enc_pkg::REG_MAX_TARGET, 16'd5);
        write_reg(acc_enc_pkg::REG_MIN_TARGET, 16'd5);
        send_detent(clock_ms + 32'd10, 1'b0);
        send_detent(clock_ms + 32'd11, 1'b1);
        send_detent(clock_ms + 32'd12, 1'b0); // floor is 0
        send_detent(clock_ms + 32'd13, 1'b0);
        clock_ms = clock_ms + 32'd13;
        settle_outputs();
    endtask

    // Preset slot walks and saturates at both ends.
    task automatic test_directed_preset();
        write_reg(acc_enc_pkg::REG_PRESET_ENABLE, 16'd1);
        send_detent(clock_ms, 1'b0);
        send_detent(clock_ms, 1'b1);
        send_detent(clock_ms, 1'b1);
        send_detent(clock_ms, 1'b1);
        send_detent(clock_ms, 1'b0);
        settle_outputs();
    endtask

    task automatic test_spin_default();
        apply_config(1'b0, acc_enc_pkg::MAX_TARGET_RST, acc_enc_pkg::MIN_TARGET_RST,
                     acc_enc_pkg::WINDOW_MS_RST, acc_enc_pkg::RESET_GAP_MS_RST,
                     acc_enc_pkg::FAST_THRESHOLD_RST);
        spin_detents(450, 5);
        settle_outputs();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    // back to back, so the output register fills and in_ready drops.
    task automatic test_output_hold();
        pace_gaps = 1'b0;
        hold_req  = 1'b1;
        wait (holding);
        @(posedge clk);
        spin_detents(40, 0);
        pace_gaps = 1'b1;
        settle_outputs();
    endtask

    // One-ms windows with threshold 0: every detent is a fast second, so the
    // count runs into saturation. Alternating direction keeps steps attempted.
    task automatic test_fast_saturation();
        apply_config(1'b0, 10'd1023, 10'd5, 16'd1, 16'd65535, 8'd0);
        for (int i = 0; i < 300; i++)
        begin
            clock_ms = clock_ms + 32'd1;
            send_detent(clock_ms, (i % 2) == 0);
        end
        settle_outputs();
    endtask

    task automatic test_random_mix();
        int mx;
        int mn;
        for (int p = 0; p < 12; p++)
        begin
            mx = corner_pick(5, 1023);
            mn = ($urandom_range(0, 3) == 0) ? corner_pick(5, 1023) : $urandom_range(5, mx);
            apply_config($urandom_range(0, 5) == 0, 10'(mx), 10'(mn),
                         16'(corner_pick(1, 65535)), 16'(corner_pick(1, 65535)),
                         8'(corner_pick(0, 255)));
            if ($urandom_range(0, 3) == 0)
                clock_ms = 32'hFFFF_0000 + $urandom_range(0, 65535);
            spin_detents(30, 15);
            // sometimes the sender pauses until everything has drained
            if ($urandom_range(0, 1) == 1)
                settle_outputs();
            spin_detents(30, 15);
            settle_outputs();
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: changing ready patterns, plus one long hold on request
    // ------------------------------------------------------------------
    initial
    begin : sink
        int mode;
        int run_len;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                holding = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holding  = 1'b0;
                hold_req = 1'b0;
            end
            mode    = $urandom_range(0, 2);
            run_len = $urandom_range(10, 80);
            for (int k = 0; k < run_len; k++)
            begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= (k % 4) != 3;
                endcase
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker, sampled mid-cycle
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : check
        acc_enc_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (setpoint_q.size() == 0)
            begin
                error_cnt++;
                if (error_cnt <= 10)
                    $display("unexpected result: target %0d step %0d slot %0d",
                             out_item.target_temp, out_item.applied_step,
                             out_item.preset_index);
            end
            else
            begin
                want = setpoint_q.pop_front();
                if (out_item.target_temp !== want.target_temp ||
                    out_item.applied_step !== want.applied_step ||
                    out_item.preset_index !== want.preset_index)
                begin
                    error_cnt++;
                    if (error_cnt <= 10)
                        $display("mismatch (exp/act): target %0d/%0d step %0d/%0d slot %0d/%0d",
                                 want.target_temp, out_item.target_temp,
                                 want.applied_step, out_item.applied_step,
                                 want.preset_index, out_item.preset_index);
                end
            end
        end
    end

    // Watchdog on forward progress
    always @(negedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Run order
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_index = acc_enc_pkg::REG_PRESET_ENABLE;
        cfg_data  = '0;
        reset_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_tracker();
        test_directed_limits();
        test_directed_preset();
        test_spin_default();
        test_output_hold();
        test_fast_saturation();
        test_random_mix();

        settle_outputs();
        repeat (8) @(posedge clk);
        if (error_cnt == 0 && setpoint_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
